// File: sv/dohs_pkg.sv
package dohs_pkg;

  localparam logic [2:0] OP_BEGIN   = 3'd0;
  localparam logic [2:0] OP_PUBLISH = 3'd1;
  localparam logic [2:0] OP_TAKE    = 3'd2;
  localparam logic [2:0] OP_FINISH  = 3'd3;
  localparam logic [2:0] OP_DISABLE = 3'd4;

  // phase codes as seen on phase_out
  localparam logic [2:0] PC_DISABLED  = 3'd0;
  localparam logic [2:0] PC_IDLE      = 3'd1;
  localparam logic [2:0] PC_ENTERED   = 3'd2;
  localparam logic [2:0] PC_PUBLISHED = 3'd3;
  localparam logic [2:0] PC_TAKEN     = 3'd4;
  localparam logic [2:0] PC_QUEUED    = 3'd5;

  localparam logic [31:0] ALIGN_MASK = 32'd3;

  typedef enum logic [5:0] {
    PH_DISABLED  = 6'b000001,
    PH_IDLE      = 6'b000010,
    PH_ENTERED   = 6'b000100,
    PH_PUBLISHED = 6'b001000,
    PH_TAKEN     = 6'b010000,
    PH_QUEUED    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] task_id;
    logic [31:0] descriptor_word;
    logic [31:0] seq_number;
    logic        msg_queued;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] seq_out;
    logic [2:0]  phase_out;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] owner_task;
    logic [31:0] held_descriptor;
    logic [31:0] ticket_seq;
  } slot_state_t;

  function automatic logic word_ok(input logic [31:0] w);
    return (w != 32'd0) && ((w & ALIGN_MASK) == 32'd0);
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    case (ph)
      PH_DISABLED:  c = PC_DISABLED;
      PH_IDLE:      c = PC_IDLE;
      PH_ENTERED:   c = PC_ENTERED;
      PH_PUBLISHED: c = PC_PUBLISHED;
      PH_TAKEN:     c = PC_TAKEN;
      PH_QUEUED:    c = PC_QUEUED;
      default:      c = PC_DISABLED;
    endcase
    return c;
  endfunction

endpackage

// File: sv/dohs_in_stage.sv
module dohs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dohs_pkg::in_item_t in_data,
  output logic              stg_valid,
  input  logic              stg_take,
  output dohs_pkg::in_item_t stg_item
);

  logic               valid_r;
  logic               valid_nxt;
  dohs_pkg::in_item_t item_r;

  assign in_ready  = !valid_r || stg_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !stg_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stg_valid = valid_r;
  assign stg_item  = item_r;

endmodule

// File: sv/dohs_step.sv
module dohs_step (
  input  dohs_pkg::in_item_t    item,
  input  dohs_pkg::slot_state_t cur,
  output dohs_pkg::slot_state_t nxt,
  output dohs_pkg::out_item_t   res
);

  dohs_pkg::slot_state_t st_dis;
  dohs_pkg::slot_state_t st_idle;
  logic                  owner_match;

  always_comb begin
    st_dis                 = cur;
    st_dis.phase           = dohs_pkg::PH_DISABLED;
    st_dis.owner_task      = 32'd0;
    st_dis.held_descriptor = 32'd0;
    st_idle                = st_dis;
    st_idle.phase          = dohs_pkg::PH_IDLE;
  end

  assign owner_match = (item.task_id != 32'd0) && (item.task_id == cur.owner_task);

  always_comb begin
    nxt          = cur;
    res.accepted = 1'b0;
    res.seq_out  = 32'd0;
    case (item.opcode)
      dohs_pkg::OP_BEGIN: begin
        if (cur.phase == dohs_pkg::PH_IDLE && dohs_pkg::word_ok(item.task_id)) begin
          nxt.ticket_seq = item.seq_number;
          nxt.owner_task = item.task_id;
          nxt.phase      = dohs_pkg::PH_ENTERED;
          res.accepted   = 1'b1;
        end
      end
      dohs_pkg::OP_PUBLISH: begin
        if (owner_match) begin
          if (cur.phase != dohs_pkg::PH_ENTERED ||
              !dohs_pkg::word_ok(item.descriptor_word)) begin
            nxt = st_dis;
          end else begin
            nxt.held_descriptor = item.descriptor_word;
            nxt.phase           = dohs_pkg::PH_PUBLISHED;
            res.accepted        = 1'b1;
          end
        end
      end
      dohs_pkg::OP_TAKE: begin
        if ((cur.phase inside {dohs_pkg::PH_PUBLISHED, dohs_pkg::PH_QUEUED}) &&
            item.descriptor_word != 32'd0 &&
            item.descriptor_word == cur.held_descriptor) begin
          if (cur.phase == dohs_pkg::PH_QUEUED) begin
            nxt = st_idle;
          end else begin
            nxt.held_descriptor = 32'd0;
            nxt.phase           = dohs_pkg::PH_TAKEN;
          end
          res.accepted = 1'b1;
          res.seq_out  = cur.ticket_seq;
        end
      end
      dohs_pkg::OP_FINISH: begin
        if (!owner_match ||
            !(cur.phase inside {dohs_pkg::PH_ENTERED, dohs_pkg::PH_PUBLISHED,
                                dohs_pkg::PH_TAKEN})) begin
          nxt = st_dis;
        end else if (item.msg_queued) begin
          if (cur.phase == dohs_pkg::PH_PUBLISHED) begin
            // descriptor stays for the consumer, owner is released
            nxt.phase      = dohs_pkg::PH_QUEUED;
            nxt.owner_task = 32'd0;
          end else if (cur.phase == dohs_pkg::PH_TAKEN) begin
            nxt = st_idle;
          end else begin
            nxt = st_dis;
          end
        end else if (cur.phase == dohs_pkg::PH_TAKEN) begin
          nxt = st_dis;
        end else begin
          nxt = st_idle;
        end
      end
      dohs_pkg::OP_DISABLE: begin
        nxt = st_dis;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.phase_out = dohs_pkg::phase_code(nxt.phase);
  end

endmodule

// File: sv/descriptor_ownership_handshake_fsm_core.sv
// Channel | Ports                          | Handshake
// input   | in_valid, in_ready, in_data    | valid/ready, in_item_t
// result  | out_valid, out_ready, out_data | valid/ready, out_item_t
//
// One item per cycle sustained while out_ready is not held low; an accepted item
// goes into the input register, then through step logic into the result register.
// Slot state updates as an item moves into the result register.
// Synchronous active-low reset: slot goes idle, owner/descriptor/ticket zero.
// A stall on out_ready holds the result; the input register still takes one
// item behind it before in_ready drops.
module descriptor_ownership_handshake_fsm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dohs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dohs_pkg::out_item_t out_data
);

  logic                  stg_valid;
  logic                  stg_take;
  dohs_pkg::in_item_t    stg_item;
  dohs_pkg::slot_state_t slot_r;
  dohs_pkg::slot_state_t slot_nxt;
  dohs_pkg::out_item_t   res;
  dohs_pkg::out_item_t   out_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  dohs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stg_valid(stg_valid),
    .stg_take (stg_take),
    .stg_item (stg_item)
  );

  dohs_step u_step (
    .item(stg_item),
    .cur (slot_r),
    .nxt (slot_nxt),
    .res (res)
  );

  assign stg_take      = stg_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = stg_take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r            <= 1'b0;
      slot_r.phase           <= dohs_pkg::PH_IDLE;
      slot_r.owner_task      <= 32'd0;
      slot_r.held_descriptor <= 32'd0;
      slot_r.ticket_seq      <= 32'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (stg_take) begin
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(slot_r.phase))
    else $error("slot phase not one-hot");

  a_disabled_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r.phase == dohs_pkg::PH_DISABLED |=> slot_r.phase == dohs_pkg::PH_DISABLED)
    else $error("left disabled phase without reset");

  a_owner_phase: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r.owner_task != 32'd0 |->
      (slot_r.phase == dohs_pkg::PH_ENTERED || slot_r.phase == dohs_pkg::PH_PUBLISHED ||
       slot_r.phase == dohs_pkg::PH_TAKEN))
    else $error("owner held in a phase without an owner");

  a_desc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r.held_descriptor != 32'd0 |->
      (slot_r.phase == dohs_pkg::PH_PUBLISHED || slot_r.phase == dohs_pkg::PH_QUEUED))
    else $error("descriptor held outside published/queued");

  a_accept_not_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.accepted |-> out_r.phase_out != dohs_pkg::PC_DISABLED)
    else $error("accepted item reports disabled phase");

endmodule
